// File: sv/kfpms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfpms_pkg
// Types, codes and reset values shared by the key fob power mode sequencer.
// ----------------------------------------------------------------------------
package kfpms_pkg;

   localparam int TIMER_WIDTH_DEF = 20;
   localparam int MS_WIDTH        = 20;
   localparam int BATT_WIDTH      = 7;
   localparam int FUNC_WIDTH      = 4;
   localparam int MODE_WIDTH      = 3;
   localparam int SCAN_WIDTH      = 2;
   localparam int CSR_IDX_WIDTH   = 3;

   // modes
   localparam logic [MODE_WIDTH-1:0] MODE_INIT    = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_SLEEP   = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_SLOW    = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_STANDBY = 3'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_AUTH    = 3'd4;
   localparam logic [MODE_WIDTH-1:0] MODE_FAST    = 3'd5;
   localparam logic [MODE_WIDTH-1:0] MODE_CONN    = 3'd6;
   localparam logic [MODE_WIDTH-1:0] MODE_FREEZE  = 3'd7;

   // events
   localparam logic [FUNC_WIDTH-1:0] FUNC_INIT_DONE = 4'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_WALK      = 4'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_STILL     = 4'd2;
   localparam logic [FUNC_WIDTH-1:0] FUNC_BUTTON    = 4'd3;
   localparam logic [FUNC_WIDTH-1:0] FUNC_CONN_REQ  = 4'd4;
   localparam logic [FUNC_WIDTH-1:0] FUNC_CONN_OK   = 4'd5;
   localparam logic [FUNC_WIDTH-1:0] FUNC_CONN_FAIL = 4'd6;
   localparam logic [FUNC_WIDTH-1:0] FUNC_DISCONN   = 4'd7;
   localparam logic [FUNC_WIDTH-1:0] FUNC_NO_ACCEL  = 4'd8;
   localparam logic [FUNC_WIDTH-1:0] FUNC_FREEZE    = 4'd9;
   localparam logic [FUNC_WIDTH-1:0] FUNC_UNFREEZE  = 4'd10;
   localparam logic [FUNC_WIDTH-1:0] FUNC_TICK      = 4'd11;

   // scan commands
   localparam logic [SCAN_WIDTH-1:0] SCAN_NONE = 2'd0;
   localparam logic [SCAN_WIDTH-1:0] SCAN_SLOW = 2'd1;
   localparam logic [SCAN_WIDTH-1:0] SCAN_FAST = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BATT_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_VBAT_RECHECK   = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SLOW_SCAN      = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FAST_SCAN      = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_CONNECT        = 3'd4;

   // register reset values
   localparam logic [BATT_WIDTH-1:0] BATT_THRESHOLD_RST = 7'd60;
   localparam logic [MS_WIDTH-1:0]   VBAT_RECHECK_RST   = 20'd1000;
   localparam logic [MS_WIDTH-1:0]   SLOW_SCAN_RST      = MS_WIDTH'(5 * 60 * 1000);
   localparam logic [MS_WIDTH-1:0]   FAST_SCAN_RST      = 20'd180;
   localparam logic [MS_WIDTH-1:0]   CONNECT_RST        = 20'd5000;

   typedef struct packed {
      logic [FUNC_WIDTH-1:0] func;
      logic [BATT_WIDTH-1:0] battery_level;
      logic                  disconnect_during_still;
      logic                  vehicle_locked;
      logic                  uwb_ranging_active;
   } req_word_type;

   typedef struct packed {
      logic [MODE_WIDTH-1:0] mode;
      logic [SCAN_WIDTH-1:0] scan_request;
      logic                  connect_request;
      logic                  disconnect_request;
      logic                  low_power_setup;
      logic                  uwb_notify;
      logic                  acted;
   } rsp_word_type;

   typedef struct packed {
      logic [CSR_IDX_WIDTH-1:0] index;
      logic [MS_WIDTH-1:0]      data;
   } csr_word_type;

   typedef struct packed {
      logic [BATT_WIDTH-1:0] battery_threshold;
      logic [MS_WIDTH-1:0]   vbat_recheck_ms;
      logic [MS_WIDTH-1:0]   slow_scan_ms;
      logic [MS_WIDTH-1:0]   fast_scan_ms;
      logic [MS_WIDTH-1:0]   connect_ms;
   } cfg_type;

   typedef struct packed {
      logic [MODE_WIDTH-1:0] mode;
      logic                  running;
   } seq_state_type;

endpackage
`default_nettype wire

// File: sv/kfpms_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfpms_if
// Valid/ready channels for event words, result words and register writes.
// ----------------------------------------------------------------------------
interface kfpms_req_if;
   import kfpms_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface kfpms_rsp_if;
   import kfpms_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface kfpms_csr_if;
   import kfpms_pkg::*;
   logic         valid;
   logic         ready;
   csr_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface
`default_nettype wire

// File: sv/kfpms_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kfpms_step
// Next mode, timeout counter update and command strobes for one event word.
// ----------------------------------------------------------------------------
module kfpms_step #(
   parameter int TIMER_WIDTH = kfpms_pkg::TIMER_WIDTH_DEF
) (
   input  kfpms_pkg::cfg_type       cfg,
   input  kfpms_pkg::seq_state_type cur_state,
   input  logic [TIMER_WIDTH-1:0]   cur_count,
   input  kfpms_pkg::req_word_type  req_word,
   output kfpms_pkg::seq_state_type nxt_state,
   output logic [TIMER_WIDTH-1:0]   nxt_count,
   output kfpms_pkg::rsp_word_type  rsp_word
);
   import kfpms_pkg::*;

   localparam int CMP_WIDTH = (TIMER_WIDTH > MS_WIDTH) ? TIMER_WIDTH : MS_WIDTH;
   localparam logic [CMP_WIDTH-1:0] CNT_MAX = CMP_WIDTH'({TIMER_WIDTH{1'b1}});

   logic                   start;
   logic [MS_WIDTH-1:0]    reload_ms;
   logic [CMP_WIDTH-1:0]   reload_ext;
   logic [TIMER_WIDTH-1:0] reload_cnt;
   logic [TIMER_WIDTH-1:0] count_dec;
   logic                   batt_ok;
   rsp_word_type           rsp;
   seq_state_type          st;
   logic [TIMER_WIDTH-1:0] cnt;

   assign count_dec  = cur_count - TIMER_WIDTH'(1);
   assign batt_ok    = req_word.battery_level >= cfg.battery_threshold;
   assign reload_ext = CMP_WIDTH'(reload_ms);

   // zero reload counts as one, oversized reload saturates
   always_comb begin
      if (reload_ms == '0) begin
         reload_cnt = TIMER_WIDTH'(1);
      end else if (reload_ext > CNT_MAX) begin
         reload_cnt = TIMER_WIDTH'(CNT_MAX);
      end else begin
         reload_cnt = TIMER_WIDTH'(reload_ext);
      end
   end

   always_comb begin
      st        = cur_state;
      cnt       = cur_count;
      start     = 1'b0;
      reload_ms = cfg.fast_scan_ms;
      rsp       = '0;
      case (req_word.func)
         FUNC_INIT_DONE: begin
            if (cur_state.mode == MODE_INIT) begin
               rsp.acted = 1'b1;
               if (batt_ok) begin
                  rsp.low_power_setup = 1'b1;
                  st.mode             = MODE_SLEEP;
               end else begin
                  start     = 1'b1;
                  reload_ms = cfg.vbat_recheck_ms;
               end
            end
         end
         FUNC_WALK: begin
            if (cur_state.mode == MODE_SLEEP) begin
               rsp.acted        = 1'b1;
               rsp.scan_request = SCAN_SLOW;
               start            = 1'b1;
               reload_ms        = cfg.slow_scan_ms;
               st.mode          = MODE_SLOW;
            end
         end
         FUNC_STILL: begin
            if (cur_state.mode == MODE_SLOW) begin
               rsp.acted           = 1'b1;
               st.running          = 1'b0;
               rsp.low_power_setup = 1'b1;
               st.mode             = MODE_SLEEP;
            end else if (cur_state.mode == MODE_STANDBY) begin
               rsp.acted        = 1'b1;
               rsp.scan_request = SCAN_SLOW;
               start            = 1'b1;
               st.mode          = MODE_FAST;
            end
         end
         FUNC_BUTTON: begin
            if (cur_state.mode inside {MODE_SLEEP, MODE_STANDBY}) begin
               rsp.acted        = 1'b1;
               rsp.scan_request = SCAN_FAST;
               start            = 1'b1;
               st.mode          = MODE_FAST;
            end
         end
         FUNC_CONN_REQ: begin
            if (cur_state.mode inside {MODE_SLOW, MODE_FAST}) begin
               rsp.acted           = 1'b1;
               rsp.connect_request = 1'b1;
               start               = 1'b1;
               reload_ms           = cfg.connect_ms;
               st.mode             = MODE_AUTH;
            end
         end
         FUNC_CONN_OK: begin
            if (cur_state.mode == MODE_AUTH) begin
               rsp.acted = 1'b1;
               st.mode   = MODE_CONN;
            end
         end
         FUNC_CONN_FAIL: begin
            if (cur_state.mode == MODE_AUTH) begin
               rsp.acted        = 1'b1;
               rsp.scan_request = SCAN_FAST;
               start            = 1'b1;
               st.mode          = MODE_FAST;
            end
         end
         FUNC_DISCONN: begin
            if (cur_state.mode == MODE_CONN) begin
               rsp.acted      = 1'b1;
               rsp.uwb_notify = 1'b1;
               if (req_word.disconnect_during_still) begin
                  rsp.low_power_setup = 1'b1;
                  st.mode             = MODE_SLEEP;
               end else begin
                  rsp.scan_request = SCAN_FAST;
                  start            = 1'b1;
                  st.mode          = MODE_FAST;
               end
            end
         end
         FUNC_NO_ACCEL: begin
            if (cur_state.mode == MODE_CONN) begin
               rsp.acted              = 1'b1;
               rsp.disconnect_request = req_word.vehicle_locked &
                                        ~req_word.uwb_ranging_active;
            end
         end
         FUNC_FREEZE: begin
            if (cur_state.mode inside {[MODE_SLEEP:MODE_CONN]}) begin
               rsp.acted  = 1'b1;
               st.running = 1'b0;
               st.mode    = MODE_FREEZE;
            end
         end
         FUNC_UNFREEZE: begin
            if (cur_state.mode == MODE_FREEZE) begin
               rsp.acted           = 1'b1;
               rsp.low_power_setup = 1'b1;
               st.mode             = MODE_SLEEP;
            end
         end
         FUNC_TICK: begin
            if (cur_state.running) begin
               cnt = count_dec;
               if (count_dec == '0) begin
                  // expiry acts as the mode's timeout event
                  st.running = 1'b0;
                  rsp.acted  = 1'b1;
                  case (cur_state.mode)
                     MODE_INIT: begin
                        if (batt_ok) begin
                           rsp.low_power_setup = 1'b1;
                           st.mode             = MODE_SLEEP;
                        end else begin
                           start     = 1'b1;
                           reload_ms = cfg.vbat_recheck_ms;
                        end
                     end
                     MODE_SLOW: begin
                        rsp.low_power_setup = 1'b1;
                        st.mode             = MODE_STANDBY;
                     end
                     MODE_FAST: begin
                        rsp.low_power_setup = 1'b1;
                        st.mode             = MODE_SLEEP;
                     end
                     MODE_AUTH: begin
                        rsp.scan_request = SCAN_FAST;
                        start            = 1'b1;
                        st.mode          = MODE_FAST;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         default: begin
         end
      endcase
      if (start) begin
         cnt        = reload_cnt;
         st.running = 1'b1;
      end
      rsp.mode = st.mode;
   end

   assign nxt_state = st;
   assign nxt_count = cnt;
   assign rsp_word  = rsp;

endmodule
`default_nettype wire

// File: sv/keyfob_power_mode_sequencer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyfob_power_mode_sequencer_top
// Eight-mode power and connection sequencer for a key fob.
//
// Channels: req_if takes one event word per handshake (millisecond ticks
// included), rsp_if returns exactly one result word per event, and csr_if
// writes the threshold and timeout registers; it is always ready. The user
// must see that it is written only while the block is idle, which the block
// itself does not enforce. Path: an accepted event passes the input register,
// then the result register, before its result shows on rsp_if.
// Throughput: one event per cycle while rsp_if.ready stays high, set by the
// combinational mode and timeout counter update between the two registers.
// Reset: mode goes to init, the timeout counter stops, the registers take
// their default values and both pipeline stages empty.
// Stall: while rsp_if.ready is low the result word holds, one more event
// waits in the input register, and req_if.ready then drops.
// ----------------------------------------------------------------------------
module keyfob_power_mode_sequencer_top #(
   parameter int TIMER_WIDTH = kfpms_pkg::TIMER_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   kfpms_req_if.sink   req_if,
   kfpms_rsp_if.source rsp_if,
   kfpms_csr_if.sink   csr_if
);
   import kfpms_pkg::*;

   cfg_type                cfg_ff;
   seq_state_type          state_ff;
   seq_state_type          state_in;
   logic [TIMER_WIDTH-1:0] count_ff;
   logic [TIMER_WIDTH-1:0] count_in;
   logic                   in_valid_ff;
   req_word_type           in_word_ff;
   logic                   rsp_valid_ff;
   rsp_word_type           rsp_word_ff;
   rsp_word_type           rsp_word_in;
   logic                   out_free;
   logic                   advance;
   logic                   req_fire;

   assign out_free = ~rsp_valid_ff | rsp_if.ready;
   assign advance  = in_valid_ff & out_free;
   assign req_if.ready = ~in_valid_ff | out_free;
   assign req_fire = req_if.valid & req_if.ready;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.word  = rsp_word_ff;

   kfpms_step #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_step (
      .cfg       (cfg_ff),
      .cur_state (state_ff),
      .cur_count (count_ff),
      .req_word  (in_word_ff),
      .nxt_state (state_in),
      .nxt_count (count_in),
      .rsp_word  (rsp_word_in)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.battery_threshold <= BATT_THRESHOLD_RST;
         cfg_ff.vbat_recheck_ms   <= VBAT_RECHECK_RST;
         cfg_ff.slow_scan_ms      <= SLOW_SCAN_RST;
         cfg_ff.fast_scan_ms      <= FAST_SCAN_RST;
         cfg_ff.connect_ms        <= CONNECT_RST;
      end else if (csr_if.valid && csr_if.ready) begin
         case (csr_if.word.index)
            CSR_BATT_THRESHOLD: cfg_ff.battery_threshold <= csr_if.word.data[BATT_WIDTH-1:0];
            CSR_VBAT_RECHECK:   cfg_ff.vbat_recheck_ms   <= csr_if.word.data;
            CSR_SLOW_SCAN:      cfg_ff.slow_scan_ms      <= csr_if.word.data;
            CSR_FAST_SCAN:      cfg_ff.fast_scan_ms      <= csr_if.word.data;
            CSR_CONNECT:        cfg_ff.connect_ms        <= csr_if.word.data;
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '{mode: MODE_INIT, running: 1'b0};
         count_ff     <= '0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
            count_ff <= count_in;
         end
         if (req_fire) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_word_ff <= req_if.word;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule
`default_nettype wire

// File: test/tb_keyfob_power_mode_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyfob_power_mode_sequencer_top
// Self-checking bench for the key fob power mode sequencer. A behavioral
// mode and timeout predictor runs on every accepted event word and queues the
// result word that the block must return. Directed walks cover each mode, most
// events and timer corners; random phases then replay mode-aware event streams
// under several register settings with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_keyfob_power_mode_sequencer_top;
   import kfpms_pkg::*;

   localparam int TIMER_W     = TIMER_WIDTH_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_WORDS = 205;
   localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_W) - 33'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_UNUSED_LO = 4'd12;
   localparam logic [FUNC_WIDTH-1:0] FUNC_UNUSED_HI = 4'd15;

   logic clock = 1'b0;
   logic reset;

   kfpms_req_if req_ch ();
   kfpms_rsp_if rsp_ch ();
   kfpms_csr_if csr_ch ();

   keyfob_power_mode_sequencer_top #(
      .TIMER_WIDTH(TIMER_W)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch),
      .csr_if(csr_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predicted sequencer state and registers
   logic [MODE_WIDTH-1:0] seq_mode;
   logic [32:0]           seq_count;
   logic                  seq_running;
   cfg_type               seq_cfg;

   rsp_word_type mode_reports_due[$];
   rsp_word_type due_word;

   int   mismatches      = 0;
   int   reports_checked = 0;
   int   events_sent     = 0;
   int   expiries        = 0;
   int   settings_loaded = 0;
   int   burst_left      = 0;
   int   ready_span      = 0;
   int   ready_pct       = 100;
   logic [7:0] modes_seen = '0;

   function automatic void arm_timer(input logic [MS_WIDTH-1:0] ms);
      logic [32:0] v;
      v = 33'(ms);
      if (v == 33'd0) v = 33'd1;
      if (v > TIMER_MAX) v = TIMER_MAX;
      seq_count   = v;
      seq_running = 1'b1;
   endfunction

   function automatic void enter_fast_scan();
      arm_timer(seq_cfg.fast_scan_ms);
      seq_mode = MODE_FAST;
   endfunction

   // returns the low-power strobe
   function automatic logic battery_gate(input logic [BATT_WIDTH-1:0] batt);
      if (batt >= seq_cfg.battery_threshold) begin
         seq_mode = MODE_SLEEP;
         return 1'b1;
      end
      arm_timer(seq_cfg.vbat_recheck_ms);
      return 1'b0;
   endfunction

   function automatic rsp_word_type step_sequencer(input req_word_type w);
      rsp_word_type          r;
      logic [MODE_WIDTH-1:0] m;
      r = '0;
      m = seq_mode;
      case (w.func)
         FUNC_INIT_DONE: if (m == MODE_INIT) begin
            r.acted = 1'b1;
            r.low_power_setup = battery_gate(w.battery_level);
         end
         FUNC_WALK: if (m == MODE_SLEEP) begin
            r.acted = 1'b1;
            r.scan_request = SCAN_SLOW;
            arm_timer(seq_cfg.slow_scan_ms);
            seq_mode = MODE_SLOW;
         end
         FUNC_STILL: if (m == MODE_SLOW) begin
            r.acted = 1'b1;
            seq_running = 1'b0;
            r.low_power_setup = 1'b1;
            seq_mode = MODE_SLEEP;
         end else if (m == MODE_STANDBY) begin
            r.acted = 1'b1;
            r.scan_request = SCAN_SLOW;
            enter_fast_scan();
         end
         FUNC_BUTTON: if (m == MODE_SLEEP || m == MODE_STANDBY) begin
            r.acted = 1'b1;
            r.scan_request = SCAN_FAST;
            enter_fast_scan();
         end
         FUNC_CONN_REQ: if (m == MODE_SLOW || m == MODE_FAST) begin
            r.acted = 1'b1;
            r.connect_request = 1'b1;
            arm_timer(seq_cfg.connect_ms);
            seq_mode = MODE_AUTH;
         end
         FUNC_CONN_OK: if (m == MODE_AUTH) begin
            r.acted = 1'b1;
            seq_mode = MODE_CONN;
         end
         FUNC_CONN_FAIL: if (m == MODE_AUTH) begin
            r.acted = 1'b1;
            r.scan_request = SCAN_FAST;
            enter_fast_scan();
         end
         FUNC_DISCONN: if (m == MODE_CONN) begin
            r.acted = 1'b1;
            r.uwb_notify = 1'b1;
            if (w.disconnect_during_still) begin
               r.low_power_setup = 1'b1;
               seq_mode = MODE_SLEEP;
            end else begin
               r.scan_request = SCAN_FAST;
               enter_fast_scan();
            end
         end
         FUNC_NO_ACCEL: if (m == MODE_CONN) begin
            r.acted = 1'b1;
            r.disconnect_request = w.vehicle_locked && !w.uwb_ranging_active;
         end
         FUNC_FREEZE: if (m >= MODE_SLEEP && m <= MODE_CONN) begin
            r.acted = 1'b1;
            seq_running = 1'b0;
            seq_mode = MODE_FREEZE;
         end
         FUNC_UNFREEZE: if (m == MODE_FREEZE) begin
            r.acted = 1'b1;
            r.low_power_setup = 1'b1;
            seq_mode = MODE_SLEEP;
         end
         FUNC_TICK: if (seq_running) begin
            seq_count = (seq_count - 33'd1) & TIMER_MAX;
            if (seq_count == 33'd0) begin
               seq_running = 1'b0;
               r.acted = 1'b1;
               expiries++;
               case (m)
                  MODE_INIT: r.low_power_setup = battery_gate(w.battery_level);
                  MODE_SLOW: begin
                     r.low_power_setup = 1'b1;
                     seq_mode = MODE_STANDBY;
                  end
                  MODE_FAST: begin
                     r.low_power_setup = 1'b1;
                     seq_mode = MODE_SLEEP;
                  end
                  MODE_AUTH: begin
                     r.scan_request = SCAN_FAST;
                     enter_fast_scan();
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      r.mode = seq_mode;
      return r;
   endfunction

   function automatic string describe_result(input rsp_word_type r);
      return $sformatf("mode=%0d scan=%0d conn=%0d disc=%0d lowp=%0d uwb=%0d acted=%0d",
                       r.mode, r.scan_request, r.connect_request, r.disconnect_request,
                       r.low_power_setup, r.uwb_notify, r.acted);
   endfunction

   // sender: bursts of random length, random gaps in between
   task automatic send_event(input req_word_type w, output rsp_word_type due);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.word  <= w;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      due = step_sequencer(w);
      mode_reports_due.push_back(due);
      events_sent++;
   endtask

   task automatic play(input logic [FUNC_WIDTH-1:0] f, input int batt,
                       input logic dds, input logic locked, input logic ranging);
      req_word_type w;
      rsp_word_type due;
      w.func                    = f;
      w.battery_level           = BATT_WIDTH'(batt);
      w.disconnect_during_still = dds;
      w.vehicle_locked          = locked;
      w.uwb_ranging_active      = ranging;
      send_event(w, due);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (mode_reports_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // valid stays high across back-to-back writes
   task automatic write_csr(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [MS_WIDTH-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.word  <= {idx, data};
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      case (idx)
         CSR_BATT_THRESHOLD: seq_cfg.battery_threshold = data[BATT_WIDTH-1:0];
         CSR_VBAT_RECHECK:   seq_cfg.vbat_recheck_ms   = data;
         CSR_SLOW_SCAN:      seq_cfg.slow_scan_ms      = data;
         CSR_FAST_SCAN:      seq_cfg.fast_scan_ms      = data;
         CSR_CONNECT:        seq_cfg.connect_ms        = data;
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic [BATT_WIDTH-1:0] thr,
                                input logic [MS_WIDTH-1:0] vbat, input logic [MS_WIDTH-1:0] slow,
                                input logic [MS_WIDTH-1:0] fast, input logic [MS_WIDTH-1:0] conn);
      write_csr(CSR_BATT_THRESHOLD, MS_WIDTH'(thr));
      write_csr(CSR_VBAT_RECHECK, vbat);
      write_csr(CSR_SLOW_SCAN, slow);
      write_csr(CSR_FAST_SCAN, fast);
      write_csr(CSR_CONNECT, conn);
      csr_ch.valid <= 1'b0;
      settings_loaded++;
   endtask

   // defaults after reset: low battery arms the recheck, a tick counts it down, init ignores the rest
   task automatic test_reset_defaults();
      play(FUNC_INIT_DONE, 59, 1'b0, 1'b0, 1'b0);
      play(FUNC_UNUSED_LO, 100, 1'b1, 1'b1, 1'b1);
      play(FUNC_TICK, 0, 1'b0, 1'b0, 1'b0);
      play(FUNC_FREEZE, 0, 1'b0, 1'b0, 1'b0);
      wait_idle();
   endtask

   // every mode, every event but button, zero reload, restart, expiry in init, slow, auth and connected modes
   task automatic test_mode_walk();
      load_settings(7'd100, 20'd0, 20'd2, 20'd3, 20'd2);
      play(FUNC_INIT_DONE, 99, 1'b0, 1'b0, 1'b0);
      play(FUNC_UNUSED_HI, 0, 1'b0, 1'b0, 1'b0);
      play(FUNC_TICK, 100, 1'b0, 1'b0, 1'b0);
      play(FUNC_TICK, 0, 1'b0, 1'b0, 1'b0);
      play(FUNC_WALK, 0, 1'b0, 1'b0, 1'b0);
      play(FUNC_STILL, 0, 1'b0, 1'b0, 1'b0);
      play(FUNC_WALK, 0, 1'b0, 1'b0, 1'b0);
      play(FUNC_TICK, 0, 1'b0, 1'b0, 1'b0);
      play(FUNC_TICK, 0, 1'b0, 1'b0, 1'b0);
      play(FUNC_STILL, 0, 1'b0, 1'b0, 1'b0);
      play(FUNC_CONN_REQ, 0, 1'b0, 1'b0, 1'b0);
      play(FUNC_TICK, 0, 1'b0, 1'b0, 1'b0);
      play(FUNC_TICK, 0, 1'b0, 1'b0, 1'b0);
      play(FUNC_CONN_REQ, 0, 1'b0, 1'b0, 1'b0);
      play(FUNC_CONN_FAIL, 0, 1'b0, 1'b0, 1'b0);
      play(FUNC_CONN_REQ, 0, 1'b0, 1'b0, 1'b0);
      play(FUNC_CONN_OK, 0, 1'b0, 1'b0, 1'b0);
      play(FUNC_NO_ACCEL, 0, 1'b0, 1'b1, 1'b0);
      play(FUNC_NO_ACCEL, 0, 1'b0, 1'b1, 1'b1);
      play(FUNC_TICK, 0, 1'b0, 1'b0, 1'b0);
      play(FUNC_TICK, 0, 1'b0, 1'b0, 1'b0);
      play(FUNC_DISCONN, 0, 1'b0, 1'b0, 1'b0);
      play(FUNC_FREEZE, 0, 1'b0, 1'b0, 1'b0);
      play(FUNC_UNFREEZE, 0, 1'b0, 1'b0, 1'b0);
      wait_idle();
   endtask

   // mostly events the current mode handles, plus ticks and noise
   function automatic req_word_type pick_event();
      req_word_type w;
      int           roll;
      w.battery_level           = BATT_WIDTH'($urandom_range(0, 100));
      w.disconnect_during_still = 1'($urandom_range(0, 1));
      w.vehicle_locked          = 1'($urandom_range(0, 1));
      w.uwb_ranging_active      = 1'($urandom_range(0, 1));
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
         w.func = FUNC_WIDTH'($urandom_range(0, 15));
      end else if (roll < 45) begin
         w.func = FUNC_TICK;
      end else if (roll < 52) begin
         w.func = (seq_mode == MODE_FREEZE) ? FUNC_UNFREEZE : FUNC_FREEZE;
      end else begin
         case (seq_mode)
            MODE_INIT:    w.func = FUNC_INIT_DONE;
            MODE_SLEEP:   w.func = $urandom_range(0, 1) ? FUNC_WALK : FUNC_BUTTON;
            MODE_SLOW:    w.func = $urandom_range(0, 1) ? FUNC_STILL : FUNC_CONN_REQ;
            MODE_STANDBY: w.func = $urandom_range(0, 1) ? FUNC_STILL : FUNC_BUTTON;
            MODE_AUTH:    w.func = $urandom_range(0, 1) ? FUNC_CONN_OK : FUNC_CONN_FAIL;
            MODE_FAST:    w.func = FUNC_CONN_REQ;
            MODE_CONN:    w.func = $urandom_range(0, 1) ? FUNC_DISCONN : FUNC_NO_ACCEL;
            default:      w.func = FUNC_UNFREEZE;
         endcase
      end
      return w;
   endfunction

   task automatic test_random_phase(input logic [BATT_WIDTH-1:0] thr,
                                    input logic [MS_WIDTH-1:0] vbat,
                                    input logic [MS_WIDTH-1:0] slow,
                                    input logic [MS_WIDTH-1:0] fast,
                                    input logic [MS_WIDTH-1:0] conn);
      req_word_type w;
      rsp_word_type due;
      int           counted;
      counted = 0;
      load_settings(thr, vbat, slow, fast, conn);
      while (counted < PHASE_WORDS) begin
         w = pick_event();
         send_event(w, due);
         counted++;
      end
      wait_idle();
   endtask

   // receiver: ready pattern switches between free, light and heavy stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (mode_reports_due.size() == 0) begin
               $display("%0t: result word with none pending, expected none, actual %s",
                        $time, describe_result(rsp_ch.word));
               mismatches++;
            end else begin
               due_word = mode_reports_due.pop_front();
               reports_checked++;
               if (rsp_ch.word !== due_word) begin
                  $display("%0t: result mismatch, expected %s, actual %s", $time,
                           describe_result(due_word), describe_result(rsp_ch.word));
                  mismatches++;
               end
            end
            modes_seen[rsp_ch.word.mode] = 1'b1;
         end
         if (ready_span == 0) begin
            ready_span = $urandom_range(20, 150);
            case ($urandom_range(0, 2))
               0:       ready_pct = 100;
               1:       ready_pct = 70;
               default: ready_pct = 30;
            endcase
         end else begin
            ready_span--;
         end
         rsp_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("keyfob_power_mode_sequencer_top verification failed");
      $finish;
   end

   initial begin
      seq_mode    = MODE_INIT;
      seq_count   = '0;
      seq_running = 1'b0;
      seq_cfg     = {BATT_THRESHOLD_RST, VBAT_RECHECK_RST, SLOW_SCAN_RST,
                     FAST_SCAN_RST, CONNECT_RST};
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.word  <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.word  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_mode_walk();
      test_random_phase(7'd0, 20'd1, 20'd1, 20'd1, 20'd1);
      test_random_phase(7'd100, 20'd1000000, 20'd1000000, 20'd1000000, 20'd1000000);
      test_random_phase(7'd50, 20'd0, 20'd0, 20'd0, 20'd0);
      test_random_phase(BATT_WIDTH'($urandom_range(0, 100)),
                        MS_WIDTH'($urandom_range(1, 16)), MS_WIDTH'($urandom_range(1, 16)),
                        MS_WIDTH'($urandom_range(1, 16)), MS_WIDTH'($urandom_range(1, 16)));
      test_random_phase(BATT_THRESHOLD_RST, VBAT_RECHECK_RST, SLOW_SCAN_RST,
                        FAST_SCAN_RST, CONNECT_RST);

      $display("sent %0d event words over %0d register settings, %0d results compared",
               events_sent, settings_loaded, reports_checked);
      $display("timer expiries %0d, modes reported (7..0) %b", expiries, modes_seen);
      if (mismatches == 0) begin
         $display("keyfob_power_mode_sequencer_top verification clean");
      end else begin
         $display("keyfob_power_mode_sequencer_top verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
sv/kfpms_pkg.sv
sv/kfpms_if.sv
sv/kfpms_step.sv
sv/keyfob_power_mode_sequencer_top.sv
test/tb_keyfob_power_mode_sequencer_top.sv
